/* sv/sle_pkg.sv */
// Shared types and codes for the sequential list engine.
// Holds command, status and cell-operation codes and the cell control struct.
// No dependencies.
package sle_pkg;

  // Entry width
  localparam int DW = 32;

  // Command codes
  localparam logic [3:0] CMD_CREATE  = 4'd0;
  localparam logic [3:0] CMD_DESTROY = 4'd1;
  localparam logic [3:0] CMD_CLEAR   = 4'd2;
  localparam logic [3:0] CMD_LENGTH  = 4'd3;
  localparam logic [3:0] CMD_GET     = 4'd4;
  localparam logic [3:0] CMD_LOCATE  = 4'd5;
  localparam logic [3:0] CMD_PRIOR   = 4'd6;
  localparam logic [3:0] CMD_NEXT    = 4'd7;
  localparam logic [3:0] CMD_INSERT  = 4'd8;
  localparam logic [3:0] CMD_DELETE  = 4'd9;

  // Status codes
  localparam logic [2:0] STS_OK          = 3'd0;
  localparam logic [2:0] STS_NO_LIST     = 3'd1;
  localparam logic [2:0] STS_BAD_POS     = 3'd2;
  localparam logic [2:0] STS_NOT_FOUND   = 3'd3;
  localparam logic [2:0] STS_NO_NEIGHBOR = 3'd4;
  localparam logic [2:0] STS_FULL        = 3'd5;
  localparam logic [2:0] STS_EXISTS      = 3'd6;

  // Cell operations
  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_ROT  = 2'd1;  // take the upper neighbor (ring rotate)
  localparam logic [1:0] OP_INS  = 2'd2;  // open a slot at pos0, shift tail up
  localparam logic [1:0] OP_DEL  = 2'd3;  // close the slot at pos0, shift tail down

  // Control broadcast to every cell
  typedef struct packed {
    logic [1:0]    op;
    logic [7:0]    pos0;  // 0-based slot
    logic [DW-1:0] val;
  } cell_ctl_t;

endpackage

/* sv/sle_cell.sv */
// One storage cell of the list chain: holds a single entry.
// Moves data to or from its neighbors as the broadcast control says.
// Depends on sle_pkg.
module sle_cell #(
  parameter int IDX = 0
) (
  input  logic                      clk,
  input  sle_pkg::cell_ctl_t        ctl,
  input  logic [sle_pkg::DW-1:0]    up_i,  // entry of cell IDX+1 (ring)
  input  logic [sle_pkg::DW-1:0]    dn_i,  // entry of cell IDX-1
  output logic [sle_pkg::DW-1:0]    q
);
  import sle_pkg::*;

  logic [DW-1:0] q_r;
  logic [DW-1:0] q_nxt;

  // Next entry from the broadcast operation and this cell's place
  always_comb begin
    q_nxt = q_r;
    case (ctl.op)
      OP_ROT: begin
        q_nxt = up_i;
      end
      OP_INS: begin
        if (IDX > int'(ctl.pos0)) begin
          q_nxt = dn_i;
        end else if (IDX == int'(ctl.pos0)) begin
          q_nxt = ctl.val;
        end
      end
      OP_DEL: begin
        if (IDX >= int'(ctl.pos0)) begin
          q_nxt = up_i;
        end
      end
      default: begin
        q_nxt = q_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

/* sv/sequential_list_engine_unit.sv */
// Sequential list engine: an ordered list of up to CAPACITY signed 32-bit
// values held in a ring of storage cells, one entry per cell. Create, destroy,
// clear, length, insert and every rejected command finish in the cycle they
// are accepted. Get, locate, prior, next and a delete with a good position
// rotate the whole ring once past the head cell while a scanner watches it,
// then finish (and, for delete, close the gap in one parallel shift). The
// result sits in an output register; a new command is taken once the block is
// idle and that register is free or being read in the same cycle.
// Depends on sle_pkg and sle_cell.
module sequential_list_engine_unit #(
  parameter int CAPACITY = 128
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // command channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [3:0]                      in_cmd,
  input  logic [7:0]                      in_position,
  input  logic signed [sle_pkg::DW-1:0]   in_value,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      out_status,
  output logic signed [sle_pkg::DW-1:0]   out_data,
  output logic [7:0]                      out_found_index,
  output logic [7:0]                      out_length
);
  import sle_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);   // element count
  localparam int IW = $clog2(CAPACITY);       // cell index
  localparam int PW = ((CW > 8) ? CW : 8) + 1; // position compares

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  // Control state
  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          exists_r, exists_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Command held for a scan
  logic [3:0]    cmd_r, cmd_nxt;
  logic [7:0]    pos_r, pos_nxt;
  logic [DW-1:0] val_r, val_nxt;

  // Scanner
  logic [IW-1:0] step_r, step_nxt;
  logic [IW-1:0] k_r, k_nxt;
  logic          found_r, found_nxt;
  logic          grab_r, grab_nxt;
  logic          nb_r, nb_nxt;
  logic [DW-1:0] prev_r, prev_nxt;
  logic [DW-1:0] data_r, data_nxt;

  // Output register
  logic [2:0]    out_status_r, out_status_nxt;
  logic [DW-1:0] out_data_r, out_data_nxt;
  logic [7:0]    out_found_index_r, out_found_index_nxt;
  logic [7:0]    out_length_r, out_length_nxt;

  logic          in_acc;
  logic          res_load;
  logic [2:0]    res_status;
  logic [DW-1:0] res_data;
  logic [7:0]    res_idx;
  logic          pos_ok_get;
  logic          pos_ok_ins;
  logic          list_full;
  logic          in_list;
  logic          pos_hit;
  logic [IW:0]   k_inc;
  cell_ctl_t     ctl;
  logic [DW-1:0] cell_q [CAPACITY];
  logic [DW-1:0] head;

  // Cell ring: cell i takes from i+1 on rotate, the last one from cell 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int UP = (i + 1) % CAPACITY;
    logic [DW-1:0] dn;
    if (i == 0) begin : g_first
      assign dn = '0;
    end else begin : g_rest
      assign dn = cell_q[i-1];
    end
    sle_cell #(
      .IDX (i)
    ) u_cell (
      .clk  (clk),
      .ctl  (ctl),
      .up_i (cell_q[UP]),
      .dn_i (dn),
      .q    (cell_q[i])
    );
  end

  assign head = cell_q[0];

  // Handshake
  assign in_stall = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;

  // Position checks against the current length
  assign pos_ok_get = (in_position != 8'd0) && (PW'(in_position) <= PW'(count_r));
  assign pos_ok_ins = (in_position != 8'd0) &&
                      (PW'(in_position) <= (PW'(count_r) + PW'(1)));
  assign list_full  = (count_r == CW'(CAPACITY));

  // Scan helpers: head holds original entry step_r
  assign in_list = (CW'(step_r) < count_r);
  assign pos_hit = (PW'(step_r) == (PW'(pos_r) - PW'(1)));
  assign k_inc   = {1'b0, k_r} + {{IW{1'b0}}, 1'b1};

  // Command decode, scanner and result
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    exists_nxt = exists_r;
    cmd_nxt    = cmd_r;
    pos_nxt    = pos_r;
    val_nxt    = val_r;
    step_nxt   = step_r;
    k_nxt      = k_r;
    found_nxt  = found_r;
    grab_nxt   = grab_r;
    nb_nxt     = nb_r;
    prev_nxt   = prev_r;
    data_nxt   = data_r;
    res_load   = 1'b0;
    res_status = STS_OK;
    res_data   = '0;
    res_idx    = '0;
    ctl.op     = OP_HOLD;
    ctl.pos0   = pos_r - 8'd1;
    ctl.val    = val_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_nxt   = in_cmd;
          pos_nxt   = in_position;
          val_nxt   = in_value;
          step_nxt  = '0;
          found_nxt = 1'b0;
          grab_nxt  = 1'b0;
          nb_nxt    = 1'b0;
          res_load  = 1'b1;
          if (in_cmd == CMD_CREATE) begin
            if (exists_r) begin
              res_status = STS_EXISTS;
            end else begin
              exists_nxt = 1'b1;
              count_nxt  = '0;
            end
          end else if (!exists_r) begin
            res_status = STS_NO_LIST;
          end else begin
            case (in_cmd)
              CMD_DESTROY: begin
                exists_nxt = 1'b0;
                count_nxt  = '0;
              end
              CMD_CLEAR: begin
                count_nxt = '0;
              end
              CMD_GET, CMD_DELETE: begin
                if (!pos_ok_get) begin
                  res_status = STS_BAD_POS;
                end else begin
                  res_load  = 1'b0;
                  state_nxt = ST_SCAN;
                end
              end
              CMD_LOCATE, CMD_PRIOR, CMD_NEXT: begin
                res_load  = 1'b0;
                state_nxt = ST_SCAN;
              end
              CMD_INSERT: begin
                if (!pos_ok_ins) begin
                  res_status = STS_BAD_POS;
                end else if (list_full) begin
                  res_status = STS_FULL;
                end else begin
                  ctl.op    = OP_INS;
                  ctl.pos0  = in_position - 8'd1;
                  ctl.val   = in_value;
                  count_nxt = count_r + CW'(1);
                end
              end
              default: begin
                res_status = STS_OK;
              end
            endcase
          end
        end
      end

      ST_SCAN: begin
        // one ring rotation per cycle
        ctl.op   = OP_ROT;
        prev_nxt = head;
        grab_nxt = 1'b0;
        step_nxt = step_r + IW'(1);
        if (step_r == IW'(CAPACITY - 1)) begin
          state_nxt = ST_FIN;
        end
        if (in_list) begin
          if (pos_hit && ((cmd_r == CMD_GET) || (cmd_r == CMD_DELETE))) begin
            data_nxt = head;
          end
          if (grab_r && (cmd_r == CMD_NEXT)) begin
            data_nxt = head;
            nb_nxt   = 1'b1;
          end
          if (!found_r && (head == val_r)) begin
            found_nxt = 1'b1;
            k_nxt     = step_r;
            grab_nxt  = 1'b1;
            if (cmd_r == CMD_PRIOR) begin
              data_nxt = prev_r;
            end
          end
        end
      end

      ST_FIN: begin
        res_load  = 1'b1;
        state_nxt = ST_IDLE;
        case (cmd_r)
          CMD_GET: begin
            res_data = data_r;
          end
          CMD_DELETE: begin
            res_data  = data_r;
            ctl.op    = OP_DEL;
            count_nxt = count_r - CW'(1);
          end
          CMD_LOCATE: begin
            if (found_r) begin
              res_idx = 8'(k_inc);
            end else begin
              res_status = STS_NOT_FOUND;
            end
          end
          CMD_PRIOR: begin
            if (!found_r) begin
              res_status = STS_NOT_FOUND;
            end else if (k_r == '0) begin
              res_status = STS_NO_NEIGHBOR;
            end else begin
              res_data = data_r;
            end
          end
          CMD_NEXT: begin
            if (!found_r) begin
              res_status = STS_NOT_FOUND;
            end else if (!nb_r) begin
              res_status = STS_NO_NEIGHBOR;
            end else begin
              res_data = data_r;
            end
          end
          default: begin
            res_status = STS_OK;
          end
        endcase
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Output register
    out_valid_nxt       = res_load || (out_valid_r && out_stall);
    out_status_nxt      = out_status_r;
    out_data_nxt        = out_data_r;
    out_found_index_nxt = out_found_index_r;
    out_length_nxt      = out_length_r;
    if (res_load) begin
      out_status_nxt      = res_status;
      out_data_nxt        = res_data;
      out_found_index_nxt = res_idx;
      out_length_nxt      = 8'(count_nxt);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      exists_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      exists_r    <= exists_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and scanner registers
  always_ff @(posedge clk) begin
    cmd_r             <= cmd_nxt;
    pos_r             <= pos_nxt;
    val_r             <= val_nxt;
    step_r            <= step_nxt;
    k_r               <= k_nxt;
    found_r           <= found_nxt;
    grab_r            <= grab_nxt;
    nb_r              <= nb_nxt;
    prev_r            <= prev_nxt;
    data_r            <= data_nxt;
    out_status_r      <= out_status_nxt;
    out_data_r        <= out_data_nxt;
    out_found_index_r <= out_found_index_nxt;
    out_length_r      <= out_length_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_data        = out_data_r;
  assign out_found_index = out_found_index_r;
  assign out_length      = out_length_r;

endmodule
